>>> design/online_repetition_detector_core_assert.svh
// assertion macros for the online repetition detector
// included by the top level, no other dependencies
`ifndef ONLINE_REPETITION_DETECTOR_CORE_ASSERT_SVH
`define ONLINE_REPETITION_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ORD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ORD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ord_pkg.sv
// shared types and constants for the online repetition detector
// no dependencies
package ord_pkg;

   typedef enum logic {
      CMD_APPEND  = 1'b0,
      CMD_RESTART = 1'b1
   } command_type;

   // per-cycle controls broadcast to every cell of the row
   typedef struct packed {
      logic shift;
      logic update;
      logic clear;
   } cell_ctrl_type;

   // a freshly found square holds two copies of its core
   localparam int unsigned SQUARE_REPEATS = 2;

endpackage

>>> design/ord_if.sv
// request and response channel interfaces, valid/ready handshake
// depends on ord_pkg
interface ord_req_if #(
   parameter int unsigned SYMBOL_WIDTH = 32
);
   logic                     valid;
   logic                     ready;
   ord_pkg::command_type     command;
   logic [SYMBOL_WIDTH-1:0]  symbol;

   modport source (output valid, output command, output symbol, input ready);
   modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface ord_rsp_if #(
   parameter int unsigned MAX_LEN     = 64,
   parameter int unsigned COUNT_WIDTH = 16
);
   localparam int unsigned LEN_WIDTH  = $clog2(MAX_LEN + 1);
   localparam int unsigned CORE_WIDTH = $clog2(MAX_LEN / 2 + 1);

   logic                    valid;
   logic                    ready;
   logic                    has_core;
   logic [LEN_WIDTH-1:0]    prefix_length;
   logic [CORE_WIDTH-1:0]   core_length;
   logic [LEN_WIDTH-1:0]    suffix_length;
   logic [COUNT_WIDTH-1:0]  repeat_count;
   logic                    suffix_broken;
   logic                    store_full;

   modport source (output valid, output has_core, output prefix_length,
                   output core_length, output suffix_length, output repeat_count,
                   output suffix_broken, output store_full, input ready);
   modport sink   (input valid, input has_core, input prefix_length,
                   input core_length, input suffix_length, input repeat_count,
                   input suffix_broken, input store_full, output ready);
endinterface

>>> design/ord_cell.sv
// one period cell: holds the symbol PERIOD places back and its match run
// depends on ord_pkg
module ord_cell #(
   parameter int unsigned PERIOD       = 1,
   parameter int unsigned SYMBOL_WIDTH = 32,
   parameter int unsigned RUN_WIDTH    = 6,
   parameter int unsigned LEN_WIDTH    = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ord_pkg::cell_ctrl_type ctrl,
   input  logic [SYMBOL_WIDTH-1:0] new_sym,
   input  logic [SYMBOL_WIDTH-1:0] prev_sym,
   input  logic [LEN_WIDTH-1:0]    fill,
   output logic [SYMBOL_WIDTH-1:0] held_sym,
   output logic                    hit
);
   logic [SYMBOL_WIDTH-1:0] tap_ff, tap_in;
   logic [RUN_WIDTH-1:0]    run_ff, run_in, run_step;
   logic                    same;

   // only compare against symbols that are really in the store
   assign same = (fill >= LEN_WIDTH'(PERIOD)) && (tap_ff == new_sym);

   always_comb begin
      if (!same) begin
         run_step = '0;
      end else if (run_ff < RUN_WIDTH'(PERIOD)) begin
         run_step = run_ff + 1'b1;
      end else begin
         run_step = run_ff;
      end
   end

   assign hit = run_step >= RUN_WIDTH'(PERIOD);

   always_comb begin
      priority if (ctrl.clear) begin
         run_in = '0;
      end else if (ctrl.update) begin
         run_in = run_step;
      end else begin
         run_in = run_ff;
      end
   end

   assign tap_in   = ctrl.shift ? prev_sym : tap_ff;
   assign held_sym = tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end
endmodule

>>> design/ord_chain.sv
// row of period cells with longest-square select and core symbol tap
// depends on ord_pkg and ord_cell
module ord_chain #(
   parameter int unsigned MAX_LEN      = 64,
   parameter int unsigned SYMBOL_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ord_pkg::cell_ctrl_type ctrl,
   input  logic [SYMBOL_WIDTH-1:0] new_sym,
   input  logic [$clog2(MAX_LEN+1)-1:0]   fill,
   input  logic [$clog2(MAX_LEN/2+1)-1:0] core_len,
   output logic [$clog2(MAX_LEN/2+1)-1:0] best,
   output logic [SYMBOL_WIDTH-1:0]        expect_sym
);
   localparam int unsigned HALF       = MAX_LEN / 2;
   localparam int unsigned LEN_WIDTH  = $clog2(MAX_LEN + 1);
   localparam int unsigned CORE_WIDTH = $clog2(HALF + 1);
   localparam int unsigned IDX_WIDTH  = (HALF > 1) ? $clog2(HALF) : 1;

   logic [SYMBOL_WIDTH-1:0] held [HALF];
   logic [HALF-1:0]         hits;
   logic [CORE_WIDTH-1:0]   core_m1;
   logic [IDX_WIDTH-1:0]    sel;

   for (genvar g = 0; g < HALF; g++) begin : g_cell
      logic [SYMBOL_WIDTH-1:0] prev;
      if (g == 0) begin : g_head
         assign prev = new_sym;
      end else begin : g_body
         assign prev = held[g-1];
      end
      ord_cell #(
         .PERIOD       (g + 1),
         .SYMBOL_WIDTH (SYMBOL_WIDTH),
         .RUN_WIDTH    (CORE_WIDTH),
         .LEN_WIDTH    (LEN_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .new_sym  (new_sym),
         .prev_sym (prev),
         .fill     (fill),
         .held_sym (held[g]),
         .hit      (hits[g])
      );
   end

   // longest complete period wins
   always_comb begin
      best = '0;
      for (int p = 1; p <= HALF; p++) begin
         if (hits[p-1]) begin
            best = CORE_WIDTH'(p);
         end
      end
   end

   // while the suffix tracks the core, the expected symbol is one core length back
   assign core_m1    = core_len - 1'b1;
   assign sel        = core_m1[IDX_WIDTH-1:0];
   assign expect_sym = held[sel];
endmodule

>>> design/online_repetition_detector_core.sv
// online repetition detector top level: pattern registers, handshake, checks
// depends on ord_pkg, ord_if, ord_chain and the assertion macro header
//
// Takes one request per clock unless an untaken response stalls it: each request is a
// restart or a symbol append, and each produces exactly one response with the pattern
// after that request. A row of MAX_LEN/2 period cells, one per candidate core length,
// shifts the recent symbols along and tracks match runs, so the longest square ending
// at the newest symbol is found in the cycle the symbol arrives; the response is held
// in a register and a new request is taken in the same cycle the old response is
// taken. The cell compares and the longest-period select are combinational ahead of
// the pattern registers. No clearing pass is needed after reset.
`include "online_repetition_detector_core_assert.svh"

module online_repetition_detector_core #(
   parameter int unsigned MAX_LEN      = 64,
   parameter int unsigned SYMBOL_WIDTH = 32,
   parameter int unsigned COUNT_WIDTH  = 16
) (
   input logic clock,
   input logic reset,
   ord_req_if.sink   req_bus,
   ord_rsp_if.source rsp_bus
);
   import ord_pkg::*;

   localparam int unsigned LEN_WIDTH  = $clog2(MAX_LEN + 1);
   localparam int unsigned CORE_WIDTH = $clog2(MAX_LEN / 2 + 1);

   logic [LEN_WIDTH-1:0]   prefix_ff, prefix_in;
   logic [CORE_WIDTH-1:0]  core_ff, core_in;
   logic [LEN_WIDTH-1:0]   suffix_ff, suffix_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   broken_ff, broken_in;
   logic                   full_ff, full_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic                    is_append;
   cell_ctrl_type           ctrl;
   logic [CORE_WIDTH-1:0]   best;
   logic [SYMBOL_WIDTH-1:0] expect_sym;
   logic [LEN_WIDTH-1:0]    n1;
   logic [LEN_WIDTH:0]      two_best;
   logic [LEN_WIDTH-1:0]    s1;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_append     = req_bus.command == CMD_APPEND;

   assign ctrl.shift  = accept && is_append;
   assign ctrl.update = accept && is_append && (core_ff == '0) && !full_ff;
   assign ctrl.clear  = accept && !is_append;

   ord_chain #(
      .MAX_LEN      (MAX_LEN),
      .SYMBOL_WIDTH (SYMBOL_WIDTH)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_sym    (req_bus.symbol),
      .fill       (prefix_ff),
      .core_len   (core_ff),
      .best       (best),
      .expect_sym (expect_sym)
   );

   assign n1       = prefix_ff + 1'b1;
   assign two_best = (LEN_WIDTH + 1)'(best) << 1;
   assign s1       = suffix_ff + 1'b1;

   always_comb begin
      prefix_in = prefix_ff;
      core_in   = core_ff;
      suffix_in = suffix_ff;
      count_in  = count_ff;
      broken_in = broken_ff;
      full_in   = full_ff;
      if (accept) begin
         if (!is_append) begin
            prefix_in = '0;
            core_in   = '0;
            suffix_in = '0;
            count_in  = '0;
            broken_in = 1'b0;
            full_in   = 1'b0;
         end else if (core_ff == '0) begin
            if (!full_ff) begin
               if ((best != '0) && ((LEN_WIDTH + 1)'(n1) >= two_best)) begin
                  prefix_in = LEN_WIDTH'((LEN_WIDTH + 1)'(n1) - two_best);
                  core_in   = best;
                  suffix_in = '0;
                  broken_in = 1'b0;
                  count_in  = COUNT_WIDTH'(SQUARE_REPEATS);
               end else begin
                  prefix_in = n1;
                  full_in   = n1 >= LEN_WIDTH'(MAX_LEN);
               end
            end
         end else if (broken_ff) begin
            if (suffix_ff < LEN_WIDTH'(MAX_LEN)) begin
               suffix_in = s1;
            end
         end else if (expect_sym == req_bus.symbol) begin
            // full core seen: one more repetition, suffix starts over
            if (s1 == LEN_WIDTH'(core_ff)) begin
               suffix_in = '0;
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               suffix_in = s1;
            end
         end else begin
            broken_in = 1'b1;
            suffix_in = s1;
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= '0;
         core_ff      <= '0;
         suffix_ff    <= '0;
         count_ff     <= '0;
         broken_ff    <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prefix_ff    <= prefix_in;
         core_ff      <= core_in;
         suffix_ff    <= suffix_in;
         count_ff     <= count_in;
         broken_ff    <= broken_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pattern registers only move on a request, so they hold the pending response
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.has_core      = core_ff != '0;
   assign rsp_bus.prefix_length = prefix_ff;
   assign rsp_bus.core_length   = core_ff;
   assign rsp_bus.suffix_length = suffix_ff;
   assign rsp_bus.repeat_count  = count_ff;
   assign rsp_bus.suffix_broken = broken_ff;
   assign rsp_bus.store_full    = full_ff;

   `ORD_ASSERT_IMPLY(a_no_core_idle, clock, reset, core_ff == '0, (suffix_ff == '0) && (count_ff == '0) && !broken_ff, "pattern fields set without a core")
   `ORD_ASSERT_IMPLY(a_core_fits, clock, reset, core_ff != '0, (32'(prefix_ff) + 2 * 32'(core_ff)) <= MAX_LEN, "prefix and square exceed the store")
   `ORD_ASSERT_IMPLY(a_full_no_core, clock, reset, full_ff, core_ff == '0, "store full while a core exists")
   `ORD_ASSERT_IMPLY(a_suffix_short, clock, reset, (core_ff != '0) && !broken_ff, suffix_ff < LEN_WIDTH'(core_ff), "intact suffix reached the core length")
   `ORD_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid_ff, "request taken without a response")
endmodule
